/* hw/rtl/rsd_pkg.sv */
// Shared types and constants for the run/skip/dump frame decoder.
package rsd_pkg;

  localparam int unsigned POS_W = 21;
  localparam logic [POS_W-1:0] MAX_FRAME_PIXELS = 21'h100000;
  localparam logic [POS_W-1:0] FRAME_PIXELS_RESET = 21'd64000;

  // One result beat
  typedef struct packed {
    logic        item_kind;
    logic [19:0] pixel_offset;
    logic [13:0] run_length;
    logic [7:0]  pixel_value;
    logic [2:0]  status_code;
    logic        last_of_run;
  } rsd_result_t;

  // Results produced by one decoded byte (count is 0, 1 or 2)
  typedef struct packed {
    logic [1:0]  count;
    rsd_result_t r0;
    rsd_result_t r1;
  } rsd_push_t;

endpackage

/* hw/rtl/run_skip_dump_frame_decoder_top.sv */
// Top level of the run/skip/dump frame decoder: register port, input stage, parser, queue.
//
// Usage:
//   Record bytes enter on the byte channel (byte_valid/byte_ready, data_byte,
//   record_end high on the record's final byte). Pixel runs and one status beat
//   per record leave on the result channel (result_valid/result_ready).
//   frame_pixels is written over the APB port at address 0, by the user only while
//   the block is idle (not enforced); reads return its value. pready is always high.
// Flow:
//   An accepted byte is held in the input register; its results are then loaded
//   into the result queue register, from which the byte's first beat is shown.
//   One byte is taken per cycle while the result queue has room. A byte that
//   writes a run and also ends the record yields two beats, which the two-entry
//   queue drains one by one; the input register holds the next byte meanwhile.
// Reset and stall:
//   Synchronous reset returns the parser to the first header byte, clears the
//   frame position and empties the queue; frame_pixels returns to 64000.
//   When result_ready is low, finished beats hold, the input register keeps its
//   byte and byte_ready drops once it is full; nothing is lost.
module run_skip_dump_frame_decoder_top (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte channel
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic        record_end,
  // result channel
  output logic        result_valid,
  input  logic        result_ready,
  output logic        item_kind,
  output logic [19:0] pixel_offset,
  output logic [13:0] run_length,
  output logic [7:0]  pixel_value,
  output logic [2:0]  status_code,
  output logic        last_of_run
);
  import rsd_pkg::*;

  localparam logic REG_FRAME_PIXELS = 1'b0;

  logic [20:0] frame_pixels;
  logic        ib_valid;
  logic [7:0]  ib_byte;
  logic        ib_end;
  logic        advance;
  logic        room;
  logic        byte_beat;
  rsd_push_t   push;
  rsd_result_t head;

  // Register write and read
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FRAME_PIXELS) ? {11'd0, frame_pixels} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pixels <= FRAME_PIXELS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_PIXELS) begin
      frame_pixels <= pwdata[20:0];
    end
  end

  // Input register: load on a beat, drop when decoded
  assign advance    = ib_valid && room;
  assign byte_ready = !ib_valid || advance;
  assign byte_beat  = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (byte_beat) begin
      ib_valid <= 1'b1;
    end else if (advance) begin
      ib_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_beat) begin
      ib_byte <= data_byte;
      ib_end  <= record_end;
    end
  end

  rsd_core u_core (
    .clk          (clk),
    .rst          (rst),
    .frame_pixels (frame_pixels),
    .step         (advance),
    .data_byte    (ib_byte),
    .record_end   (ib_end),
    .push         (push)
  );

  rsd_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push_en      (advance),
    .push         (push),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .head         (head)
  );

  // Drive result fields from the queue head
  assign item_kind    = head.item_kind;
  assign pixel_offset = head.pixel_offset;
  assign run_length   = head.run_length;
  assign pixel_value  = head.pixel_value;
  assign status_code  = head.status_code;
  assign last_of_run  = head.last_of_run;

endmodule

/* hw/rtl/rsd_core.sv */
// Record parser: phase tracking, frame position and run generation per byte.
module rsd_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [20:0]               frame_pixels,
  input  logic                      step,
  input  logic [7:0]                data_byte,
  input  logic                      record_end,
  output rsd_pkg::rsd_push_t        push
);
  import rsd_pkg::*;

  typedef enum logic [3:0] {
    PH_HDR0   = 4'd0,
    PH_HDR1   = 4'd1,
    PH_HDR2   = 4'd2,
    PH_HDR3   = 4'd3,
    PH_OP     = 4'd4,
    PH_COPY   = 4'd5,
    PH_FCOUNT = 4'd6,
    PH_FPIXEL = 4'd7,
    PH_WLO    = 4'd8,
    PH_WHI    = 4'd9,
    PH_WFILL  = 4'd10,
    PH_DONE   = 4'd11
  } phase_t;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_HDR_SHORT   = 3'd1;
  localparam logic [2:0] ST_BAD_MARKER  = 3'd2;
  localparam logic [2:0] ST_FLAG_SET    = 3'd3;
  localparam logic [2:0] ST_FILL_SHORT  = 3'd4;
  localparam logic [2:0] ST_WORD_SHORT  = 3'd5;
  localparam logic [2:0] ST_BAD_OPCODE  = 3'd6;
  localparam logic [2:0] ST_FPIX_SHORT  = 3'd7;

  localparam logic [7:0]  HDR_MARKER = 8'h42;
  localparam logic [14:0] LONG_SKIP  = 15'h4000;
  localparam logic [1:0]  ESC_SKIP   = 2'd0;
  localparam logic [1:0]  ESC_LSKIP  = 2'd1;
  localparam logic [1:0]  ESC_COPY   = 2'd2;
  localparam logic [1:0]  ESC_FILL   = 2'd3;

  phase_t           parse_phase, parse_phase_next;
  logic [POS_W-1:0] frame_position, frame_position_next;
  logic [14:0]      pending_count, pending_count_next;
  logic [7:0]       low_byte_hold, low_byte_hold_next;
  logic [2:0]       record_status, record_status_next;

  logic [POS_W-1:0] size, room, take, pos_add;
  logic [14:0]      op_n, pend_dec;
  logic [13:0]      esc_cnt;
  logic [1:0]       esc_typ;
  logic             end_hit;
  logic             run_valid;
  rsd_result_t      run_res, stat_res;
  phase_t           ph_mid;
  logic [2:0]       end_status;

  // Clip the frame size and compute room left
  assign size    = (frame_pixels > MAX_FRAME_PIXELS) ? MAX_FRAME_PIXELS : frame_pixels;
  assign room    = (frame_position < size) ? (size - frame_position) : '0;
  assign esc_cnt = {data_byte[5:0], low_byte_hold};
  assign esc_typ = data_byte[7:6];
  assign pend_dec = pending_count - 15'd1;

  // Select the count that the shared clipped add works on
  always_comb begin
    case (parse_phase)
      PH_OP:     op_n = {8'd0, data_byte[6:0]};
      PH_COPY:   op_n = 15'd1;
      PH_FPIXEL: op_n = pending_count;
      PH_WFILL:  op_n = pending_count;
      PH_WHI:    op_n = (esc_typ == ESC_LSKIP) ? ({1'b0, esc_cnt} + LONG_SKIP)
                                               : {1'b0, esc_cnt};
      default:   op_n = '0;
    endcase
  end

  assign take    = ({6'd0, op_n} < room) ? {6'd0, op_n} : room;
  assign pos_add = frame_position + take;
  assign end_hit = (pos_add >= size);

  // Decode one byte
  always_comb begin
    ph_mid              = parse_phase;
    frame_position_next = frame_position;
    pending_count_next  = pending_count;
    low_byte_hold_next  = low_byte_hold;
    record_status_next  = record_status;
    run_valid           = 1'b0;
    run_res             = '0;
    run_res.pixel_offset = frame_position[19:0];
    run_res.pixel_value  = data_byte;
    run_res.run_length   = take[13:0];

    case (parse_phase)
      PH_HDR0: begin
        if (data_byte != HDR_MARKER) record_status_next = ST_BAD_MARKER;
        ph_mid = PH_HDR1;
      end
      PH_HDR1: begin
        if (data_byte != 8'd0 && record_status == ST_OK) record_status_next = ST_FLAG_SET;
        ph_mid = PH_HDR2;
      end
      PH_HDR2: ph_mid = PH_HDR3;
      PH_HDR3: ph_mid = (record_status != ST_OK) ? PH_DONE : PH_OP;
      PH_OP: begin
        if (data_byte[6:0] != 7'd0) begin
          if (!data_byte[7]) begin
            pending_count_next = {8'd0, data_byte[6:0]};
            ph_mid = PH_COPY;
          end else begin
            frame_position_next = pos_add;
            ph_mid = end_hit ? PH_DONE : PH_OP;
          end
        end else begin
          ph_mid = data_byte[7] ? PH_WLO : PH_FCOUNT;
        end
      end
      PH_COPY: begin
        run_valid = (take != '0);
        frame_position_next = pos_add;
        pending_count_next = pend_dec;
        ph_mid = end_hit ? PH_DONE : ((pend_dec == '0) ? PH_OP : PH_COPY);
      end
      PH_FCOUNT: begin
        pending_count_next = {7'd0, data_byte};
        ph_mid = PH_FPIXEL;
      end
      PH_FPIXEL: begin
        if (pending_count == '0) begin
          ph_mid = PH_OP;
        end else begin
          run_valid = (take != '0);
          frame_position_next = pos_add;
          ph_mid = end_hit ? PH_DONE : PH_OP;
        end
      end
      PH_WLO: begin
        low_byte_hold_next = data_byte;
        ph_mid = PH_WHI;
      end
      PH_WHI: begin
        if (esc_cnt == '0) begin
          case (esc_typ)
            ESC_SKIP: ph_mid = PH_DONE;
            ESC_COPY: begin
              record_status_next = ST_BAD_OPCODE;
              ph_mid = PH_DONE;
            end
            default:  ph_mid = PH_OP;
          endcase
        end else if (esc_typ == ESC_COPY) begin
          pending_count_next = {1'b0, esc_cnt};
          ph_mid = PH_COPY;
        end else if (esc_typ == ESC_FILL) begin
          pending_count_next = {1'b0, esc_cnt};
          ph_mid = PH_WFILL;
        end else begin
          frame_position_next = pos_add;
          ph_mid = end_hit ? PH_DONE : PH_OP;
        end
      end
      PH_WFILL: begin
        run_valid = (take != '0);
        frame_position_next = pos_add;
        ph_mid = end_hit ? PH_DONE : PH_OP;
      end
      default: ;
    endcase

    // Status for the record's last byte
    case (ph_mid)
      PH_HDR1, PH_HDR2, PH_HDR3: end_status = ST_HDR_SHORT;
      PH_FCOUNT, PH_FPIXEL:      end_status = ST_FILL_SHORT;
      PH_WLO, PH_WHI:            end_status = ST_WORD_SHORT;
      PH_WFILL:                  end_status = ST_FPIX_SHORT;
      PH_COPY:                   end_status = ST_OK;
      default:                   end_status = record_status_next;
    endcase

    stat_res              = '0;
    stat_res.item_kind    = 1'b1;
    stat_res.pixel_offset = frame_position_next[19:0];
    stat_res.status_code  = end_status;
    stat_res.last_of_run  = 1'b1;

    // Pack results: run first, status after it
    push = '0;
    if (run_valid) begin
      push.r0 = run_res;
      if (record_end) begin
        push.r1 = stat_res;
        push.count = 2'd2;
      end else begin
        push.r0.last_of_run = 1'b1;
        push.count = 2'd1;
      end
    end else if (record_end) begin
      push.r0 = stat_res;
      push.count = 2'd1;
    end

    // Return to reset state at the record end
    parse_phase_next = ph_mid;
    if (record_end) begin
      parse_phase_next    = PH_HDR0;
      frame_position_next = '0;
      pending_count_next  = '0;
      low_byte_hold_next  = '0;
      record_status_next  = ST_OK;
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_HDR0;
      frame_position <= '0;
      pending_count  <= '0;
      low_byte_hold  <= '0;
      record_status  <= ST_OK;
    end else if (step) begin
      parse_phase    <= parse_phase_next;
      frame_position <= frame_position_next;
      pending_count  <= pending_count_next;
      low_byte_hold  <= low_byte_hold_next;
      record_status  <= record_status_next;
    end
  end

  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    frame_position <= MAX_FRAME_PIXELS)
    else $error("frame position beyond maximum frame size");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    step && record_end |=> parse_phase == PH_HDR0 && frame_position == '0)
    else $error("parser not back at header after record end");

  a_pending_live: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_COPY || parse_phase == PH_WFILL) |-> pending_count != '0)
    else $error("copy or fill phase with zero pending count");

  a_ok_in_body: assert property (@(posedge clk) disable iff (rst)
    (parse_phase == PH_OP || parse_phase == PH_COPY || parse_phase == PH_WHI ||
     parse_phase == PH_FPIXEL || parse_phase == PH_WFILL) |-> record_status == ST_OK)
    else $error("opcode parsing continued after an error");

endmodule

/* hw/rtl/rsd_outq.sv */
// Two-entry result queue that feeds the output channel one beat per cycle while result_ready is high.
module rsd_outq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_en,
  input  rsd_pkg::rsd_push_t   push,
  output logic                 room,
  output logic                 result_valid,
  input  logic                 result_ready,
  output rsd_pkg::rsd_result_t head
);
  import rsd_pkg::*;

  rsd_result_t slot0, slot0_next;
  rsd_result_t slot1, slot1_next;
  logic [1:0]  count, count_next;
  logic        pop;
  logic [1:0]  count_after_pop;

  assign result_valid    = (count != 2'd0);
  assign head            = slot0;
  assign pop             = result_valid && result_ready;
  assign count_after_pop = count - {1'b0, pop};
  // Accept a new pair only when the queue drains to empty this cycle
  assign room            = (count == 2'd0) || (count == 2'd1 && result_ready);

  // Advance the head, then load a new pair
  always_comb begin
    slot0_next = pop ? slot1 : slot0;
    slot1_next = slot1;
    count_next = count_after_pop;
    if (push_en && push.count != 2'd0) begin
      slot0_next = push.r0;
      slot1_next = push.r1;
      count_next = push.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("result queue overfilled");

  a_push_empty: assert property (@(posedge clk) disable iff (rst)
    push_en |-> count_after_pop == 2'd0)
    else $error("result pair loaded over a pending beat");

  a_pair_drain: assert property (@(posedge clk) disable iff (rst)
    push_en && push.count == 2'd2 |=> count == 2'd2 && result_valid)
    else $error("result pair not held after load");

endmodule
